/* rtl/accel_trp_pkg.sv */
// Package for the accelerometer tilt, roll and pitch block.
// Holds default sizes, internal datapath widths, angle constants and the arctangent table.
// Used by every module of the block; depends on nothing.
package accel_trp_pkg;

  localparam int unsigned SampleWidthDef   = 16;
  localparam int unsigned AngleFracBitsDef = 13;

  // Scaled samples are always 32 bits wide; roots and CORDIC vectors need headroom.
  localparam int unsigned ScaledW  = 32;
  localparam int unsigned RadicW   = 64;
  localparam int unsigned RootW    = 32;
  localparam int unsigned VecW     = 36;
  localparam int unsigned AngW     = 35;
  localparam int unsigned CordSteps = 31;

  localparam logic signed [AngW-1:0] PiQ30     = AngW'(64'sd3373259426);
  localparam logic signed [AngW-1:0] HalfPiQ30 = AngW'(64'sd1686629713);

  typedef struct packed {
    logic signed [VecW-1:0] x;
    logic signed [VecW-1:0] y;
    logic signed [AngW-1:0] ang;
    logic                   fix;
  } cord_in_t;

  function automatic logic signed [AngW-1:0] atan_q30(input int unsigned idx);
    logic [31:0] v;
    unique case (idx)
      0:  v = 32'h3243F6A8;
      1:  v = 32'h1DAC6705;
      2:  v = 32'h0FADBAFC;
      3:  v = 32'h07F56EA6;
      4:  v = 32'h03FEAB76;
      5:  v = 32'h01FFD55B;
      6:  v = 32'h00FFFAAA;
      7:  v = 32'h007FFF55;
      8:  v = 32'h003FFFEA;
      9:  v = 32'h001FFFFD;
      10: v = 32'h000FFFFF;
      11: v = 32'h0007FFFF;
      12: v = 32'h0003FFFF;
      13: v = 32'h0001FFFF;
      14: v = 32'h0000FFFF;
      15: v = 32'h00007FFF;
      16: v = 32'h00003FFF;
      17: v = 32'h00001FFF;
      18: v = 32'h00000FFF;
      19: v = 32'h000007FF;
      20: v = 32'h000003FF;
      21: v = 32'h000001FF;
      22: v = 32'h000000FF;
      23: v = 32'h0000007F;
      24: v = 32'h0000003F;
      25: v = 32'h0000001F;
      26: v = 32'h0000000F;
      27: v = 32'h00000007;
      28: v = 32'h00000003;
      29: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return $signed(AngW'(v));
  endfunction

endpackage

/* rtl/accel_trp_sqrt.sv */
// Pipelined integer square root, one result bit per register stage.
// Carries a valid bit and a sideband word alongside the radicand; uses accel_trp_pkg.
module accel_trp_sqrt #(
  parameter int unsigned SB_W = 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic [accel_trp_pkg::RadicW-1:0]  n_i,
  input  logic [SB_W-1:0]                   sb_i,
  output logic                              valid_o,
  output logic [accel_trp_pkg::RootW-1:0]   root_o,
  output logic [SB_W-1:0]                   sb_o
);

  localparam int unsigned NW = accel_trp_pkg::RadicW;
  localparam int unsigned QW = accel_trp_pkg::RootW;
  localparam int unsigned RW = QW + 3;

  logic [RW-1:0]   rem_s  [QW+1];
  logic [QW-1:0]   root_s [QW+1];
  logic [NW-1:0]   n_s    [QW+1];
  logic [SB_W-1:0] sb_s   [QW+1];
  logic            vld_s  [QW+1];

  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign n_s[0]    = n_i;
  assign sb_s[0]   = sb_i;
  assign vld_s[0]  = valid_i;

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [RW-1:0]   rem_d, rem_q, r2, trial;
    logic [QW-1:0]   root_d, root_q;
    logic [NW-1:0]   n_q;
    logic [SB_W-1:0] sb_q;
    logic            vld_q;

    always_comb begin
      r2    = {rem_s[s][RW-3:0], n_s[s][NW-1:NW-2]};
      trial = RW'({root_s[s], 2'b01});
      if (r2 >= trial) begin
        rem_d  = r2 - trial;
        root_d = {root_s[s][QW-2:0], 1'b1};
      end else begin
        rem_d  = r2;
        root_d = {root_s[s][QW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld_s[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q  <= rem_d;
        root_q <= root_d;
        n_q    <= {n_s[s][NW-3:0], 2'b00};
        sb_q   <= sb_s[s];
      end
    end

    assign rem_s[s+1]  = rem_q;
    assign root_s[s+1] = root_q;
    assign n_s[s+1]    = n_q;
    assign sb_s[s+1]   = sb_q;
    assign vld_s[s+1]  = vld_q;
  end

  assign valid_o = vld_s[QW];
  assign root_o  = root_s[QW];
  assign sb_o    = sb_s[QW];

endmodule

/* rtl/accel_trp_cordic.sv */
// Pipelined CORDIC vectoring for several atan2 lanes in lockstep, one step per stage.
// A lane marked fixed keeps its start angle; uses accel_trp_pkg for widths and the table.
module accel_trp_cordic #(
  parameter int unsigned LANES = 3,
  parameter int unsigned SB_W  = 1
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         en_i,
  input  logic                                         valid_i,
  input  accel_trp_pkg::cord_in_t                      lane_i [LANES],
  input  logic [SB_W-1:0]                              sb_i,
  output logic                                         valid_o,
  output logic signed [accel_trp_pkg::AngW-1:0]        ang_o [LANES],
  output logic [SB_W-1:0]                              sb_o
);

  localparam int unsigned NS = accel_trp_pkg::CordSteps;

  accel_trp_pkg::cord_in_t st_s [NS+1][LANES];
  logic [SB_W-1:0]         sb_s  [NS+1];
  logic                    vld_s [NS+1];

  for (genvar l = 0; l < LANES; l++) begin : g_in
    assign st_s[0][l] = lane_i[l];
  end
  assign sb_s[0]  = sb_i;
  assign vld_s[0] = valid_i;

  for (genvar i = 0; i < NS; i++) begin : g_step
    logic            vld_q;
    logic [SB_W-1:0] sb_q;

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      accel_trp_pkg::cord_in_t cur, nxt_d, nxt_q;
      logic signed [accel_trp_pkg::VecW-1:0] xs, ys;

      always_comb begin
        cur   = st_s[i][l];
        xs    = cur.x >>> i;
        ys    = cur.y >>> i;
        nxt_d = cur;
        if (!cur.fix) begin
          if (cur.y > 0) begin
            nxt_d.x   = cur.x + ys;
            nxt_d.y   = cur.y - xs;
            nxt_d.ang = cur.ang + accel_trp_pkg::atan_q30(i);
          end else begin
            nxt_d.x   = cur.x - ys;
            nxt_d.y   = cur.y + xs;
            nxt_d.ang = cur.ang - accel_trp_pkg::atan_q30(i);
          end
        end
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          nxt_q <= nxt_d;
        end
      end

      assign st_s[i+1][l] = nxt_q;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld_s[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sb_q <= sb_s[i];
      end
    end

    assign vld_s[i+1] = vld_q;
    assign sb_s[i+1]  = sb_q;
  end

  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign ang_o[l] = st_s[NS][l].ang;
  end
  assign valid_o = vld_s[NS];
  assign sb_o    = sb_s[NS];

endmodule

/* rtl/accel_tilt_roll_pitch.sv */
// The pipeline has 68 register stages: 3 input stages, 32 root stages, 1 setup stage,
// 31 CORDIC stages and the output register. Throughput: one item per cycle; the whole
// pipeline advances together and holds while a finished result waits. Reset clears all
// valid bits and sets the Euler order to XYZ. Depends on accel_trp_pkg, accel_trp_sqrt
// and accel_trp_cordic.
module accel_tilt_roll_pitch #(
  parameter int unsigned SAMPLE_WIDTH    = accel_trp_pkg::SampleWidthDef,
  parameter int unsigned ANGLE_FRAC_BITS = accel_trp_pkg::AngleFracBitsDef,
  localparam int unsigned InW  = ((3 * SAMPLE_WIDTH + 7) / 8) * 8,
  localparam int unsigned OutW = ((3 * ANGLE_FRAC_BITS + 8 + 7) / 8) * 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_wr_en_i,
  input  logic            cfg_wr_data_i,
  input  logic            s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  logic [InW-1:0]  s_axis_tdata_i,   // acc_x, acc_y, acc_z
  output logic            m_axis_tvalid_o,
  input  logic            m_axis_tready_i,
  output logic [OutW-1:0] m_axis_tdata_o,   // tilt_angle, roll, pitch
  output logic            m_axis_tuser_o    // zero_input
);

  localparam int unsigned SW  = SAMPLE_WIDTH;
  localparam int unsigned FB  = ANGLE_FRAC_BITS;
  localparam int unsigned G   = 32 - SW;
  localparam int unsigned VW  = accel_trp_pkg::VecW;
  localparam int unsigned AW  = accel_trp_pkg::AngW;
  localparam int unsigned NW  = accel_trp_pkg::RadicW;
  localparam int unsigned QW  = accel_trp_pkg::RootW;
  localparam int unsigned CW  = accel_trp_pkg::ScaledW;
  localparam int unsigned SQW = 2 * SW;
  localparam int unsigned SBW = 3 * CW + 2;

  logic adv;
  logic order_q;

  logic                 s0_vld_q, s1_vld_q, s2_vld_q, pp_vld_q;
  logic signed [SW-1:0] s0_x_q, s0_y_q, s0_z_q;
  logic                 s0_ord_q, s1_ord_q, s2_ord_q;
  logic [SQW-1:0]       s1_xx_q, s1_yy_q, s1_zz_q;
  logic signed [CW-1:0] s1_xs_q, s1_ys_q, s1_zs_q, s2_xs_q, s2_ys_q, s2_zs_q;
  logic                 s1_zero_q, s2_zero_q;
  logic [NW-1:0]        s2_na_q, s2_nb_q;

  logic                 sqa_vld, sqb_vld;
  logic [QW-1:0]        root_a, root_b;
  logic [SBW-1:0]       sqa_sb, sqb_sb;
  logic signed [CW-1:0] q_xs, q_ys, q_zs;
  logic                 q_ord, q_zero;

  accel_trp_pkg::cord_in_t pp_d [3];
  accel_trp_pkg::cord_in_t pp_q [3];
  logic                    pp_zero_q;

  logic                 co_vld;
  logic signed [AW-1:0] co_ang [3];
  logic                 co_zero;

  logic                 out_vld_q;
  logic [OutW-1:0]      out_data_q;
  logic                 out_zero_q;
  logic [FB+1:0]        tilt_w;
  logic [FB+2:0]        roll_w, pitch_w;
  logic signed [AW-1:0] tilt_r;

  function automatic accel_trp_pkg::cord_in_t prep(input logic signed [VW-1:0] a,
                                                    input logic signed [VW-1:0] b);
    accel_trp_pkg::cord_in_t r;
    r = '0;
    if (a == 0) begin
      r.fix = 1'b1;
      r.ang = (b >= 0) ? '0 : accel_trp_pkg::PiQ30;
    end else if (b == 0) begin
      r.fix = 1'b1;
      r.ang = (a > 0) ? accel_trp_pkg::HalfPiQ30 : -accel_trp_pkg::HalfPiQ30;
    end else if (b < 0) begin
      if (a >= 0) begin
        r.x   = a;
        r.y   = -b;
        r.ang = accel_trp_pkg::HalfPiQ30;
      end else begin
        r.x   = -a;
        r.y   = b;
        r.ang = -accel_trp_pkg::HalfPiQ30;
      end
    end else begin
      r.x = b;
      r.y = a;
    end
    return r;
  endfunction

  function automatic logic signed [AW-1:0] round_ang(input logic signed [AW-1:0] q);
    logic signed [AW-1:0] c;
    c = q;
    if (c > accel_trp_pkg::PiQ30) begin
      c = accel_trp_pkg::PiQ30;
    end
    if (c < -accel_trp_pkg::PiQ30) begin
      c = -accel_trp_pkg::PiQ30;
    end
    c = c + (AW'(1) <<< (29 - FB));
    return c >>> (30 - FB);
  endfunction

  assign adv             = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= 1'b0;
    end else if (cfg_wr_en_i) begin
      order_q <= cfg_wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q  <= 1'b0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      pp_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      s0_vld_q  <= s_axis_tvalid_i;
      s1_vld_q  <= s0_vld_q;
      s2_vld_q  <= s1_vld_q;
      pp_vld_q  <= sqa_vld;
      out_vld_q <= co_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_x_q    <= $signed(s_axis_tdata_i[SW-1:0]);
      s0_y_q    <= $signed(s_axis_tdata_i[2*SW-1:SW]);
      s0_z_q    <= $signed(s_axis_tdata_i[3*SW-1:2*SW]);
      s0_ord_q  <= order_q;
      s1_xx_q   <= SQW'(s0_x_q * s0_x_q);
      s1_yy_q   <= SQW'(s0_y_q * s0_y_q);
      s1_zz_q   <= SQW'(s0_z_q * s0_z_q);
      s1_xs_q   <= CW'(s0_x_q) <<< G;
      s1_ys_q   <= CW'(s0_y_q) <<< G;
      s1_zs_q   <= CW'(s0_z_q) <<< G;
      s1_ord_q  <= s0_ord_q;
      s1_zero_q <= (s0_x_q == 0) && (s0_y_q == 0) && (s0_z_q == 0);
      s2_na_q   <= (NW'(s1_xx_q) + NW'(s1_yy_q)) << (2 * G);
      s2_nb_q   <= (NW'(s1_ord_q ? s1_xx_q : s1_yy_q) + NW'(s1_zz_q)) << (2 * G);
      s2_xs_q   <= s1_xs_q;
      s2_ys_q   <= s1_ys_q;
      s2_zs_q   <= s1_zs_q;
      s2_ord_q  <= s1_ord_q;
      s2_zero_q <= s1_zero_q;
    end
  end

  accel_trp_sqrt #(.SB_W(SBW)) u_sqrt_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s2_vld_q),
    .n_i     (s2_na_q),
    .sb_i    ({s2_xs_q, s2_ys_q, s2_zs_q, s2_ord_q, s2_zero_q}),
    .valid_o (sqa_vld),
    .root_o  (root_a),
    .sb_o    (sqa_sb)
  );

  accel_trp_sqrt #(.SB_W(SBW)) u_sqrt_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s2_vld_q),
    .n_i     (s2_nb_q),
    .sb_i    ({s2_xs_q, s2_ys_q, s2_zs_q, s2_ord_q, s2_zero_q}),
    .valid_o (sqb_vld),
    .root_o  (root_b),
    .sb_o    (sqb_sb)
  );

  assign {q_xs, q_ys, q_zs, q_ord, q_zero} = sqb_vld ? sqb_sb : sqa_sb;

  always_comb begin
    pp_d[0] = prep(VW'($signed({1'b0, root_a})), VW'(q_zs));
    if (q_ord) begin
      pp_d[1] = prep(VW'(q_ys), VW'($signed({1'b0, root_b})));
      pp_d[2] = prep(-VW'(q_xs), VW'(q_zs));
    end else begin
      pp_d[1] = prep(VW'(q_ys), VW'(q_zs));
      pp_d[2] = prep(-VW'(q_xs), VW'($signed({1'b0, root_b})));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pp_q      <= pp_d;
      pp_zero_q <= q_zero;
    end
  end

  accel_trp_cordic #(.LANES(3), .SB_W(1)) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (pp_vld_q),
    .lane_i  (pp_q),
    .sb_i    (pp_zero_q),
    .valid_o (co_vld),
    .ang_o   (co_ang),
    .sb_o    (co_zero)
  );

  always_comb begin
    tilt_r = round_ang(co_ang[0]);
    if (tilt_r < 0) begin
      tilt_r = '0;
    end
    tilt_w  = (FB+2)'(tilt_r);
    roll_w  = (FB+3)'(round_ang(co_ang[1]));
    pitch_w = (FB+3)'(round_ang(co_ang[2]));
    if (co_zero) begin
      tilt_w  = '0;
      roll_w  = '0;
      pitch_w = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= OutW'({pitch_w, roll_w, tilt_w});
      out_zero_q <= co_zero;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_zero_q;

endmodule

/* dv/accel_tilt_roll_pitch_tb.sv */
// Testbench for accel_tilt_roll_pitch: random and directed accelerometer samples under both
// Euler orders, checked against an in-bench CORDIC angle predictor. Depends on accel_trp_pkg
// and the block's RTL only.
`timescale 1ns / 100ps

module accel_tilt_roll_pitch_tb;

  localparam int unsigned SW = accel_trp_pkg::SampleWidthDef;
  localparam int unsigned FB = accel_trp_pkg::AngleFracBitsDef;
  localparam int unsigned InW = ((3 * SW + 7) / 8) * 8;
  localparam int unsigned OutW = ((3 * FB + 8 + 7) / 8) * 8;
  localparam bit OrderXyz = 1'b0;
  localparam bit OrderYxz = 1'b1;
  localparam longint PiQ = 64'sd3373259426;
  localparam longint HalfPiQ = 64'sd1686629713;
  localparam int unsigned DrainCycles = 100;

  typedef struct {
    logic [FB+1:0] tilt;
    logic [FB+2:0] roll;
    logic [FB+2:0] pitch;
    logic          zero;
  } angles_t;

  const longint atan_tbl[31] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
    64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
    64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000007, 64'h00000003, 64'h00000001,
    64'h00000000};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic cfg_wr_data = 1'b0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [InW-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OutW-1:0] m_tdata;
  logic m_tuser;

  logic [InW-1:0] sample_queue[$];
  angles_t angles_expected[$];
  bit order_model = OrderXyz;
  bit sender_hold = 1'b1;
  bit no_idle = 1'b0;
  int gap_cnt = 0;
  int stall_cnt = 0;
  int long_stall_cnt = 0;
  bit long_stall_done = 1'b0;
  int n_sent = 0;
  int n_checked = 0;
  int n_errors = 0;
  int n_zero = 0;

  accel_tilt_roll_pitch i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_wr_en_i    (cfg_wr_en),
    .cfg_wr_data_i  (cfg_wr_data),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5000000;
    $display("Timeout after %0d results checked.", n_checked);
    $display("Simulation FAILED");
    $finish;
  end

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root = 0;
    longint unsigned bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic longint magnitude(longint p, longint q);
    longint unsigned s;
    s = longint'(p * p) + longint'(q * q);
    return longint'(int_sqrt(s << (2 * (32 - SW))));
  endfunction

  function automatic longint cordic_atan2(longint a, longint b);
    longint xv, yv, ang, nx;
    if (a == 0) return (b >= 0) ? 0 : PiQ;
    if (b == 0) return (a > 0) ? HalfPiQ : -HalfPiQ;
    if (b < 0) begin
      if (a >= 0) begin
        xv = a; yv = -b; ang = HalfPiQ;
      end else begin
        xv = -a; yv = b; ang = -HalfPiQ;
      end
    end else begin
      xv = b; yv = a; ang = 0;
    end
    for (int i = 0; i < 31; i++) begin
      if (yv > 0) begin
        nx = xv + (yv >>> i);
        yv = yv - (xv >>> i);
        ang += atan_tbl[i];
      end else begin
        nx = xv - (yv >>> i);
        yv = yv + (xv >>> i);
        ang -= atan_tbl[i];
      end
      xv = nx;
    end
    return ang;
  endfunction

  function automatic longint round_to_frac(longint q);
    if (q > PiQ) q = PiQ;
    if (q < -PiQ) q = -PiQ;
    return (q + (64'sd1 << (29 - FB))) >>> (30 - FB);
  endfunction

  function automatic angles_t predict_angles(logic [InW-1:0] d, bit order);
    angles_t r;
    longint x, y, z, sc, tilt, roll, pitch;
    x = longint'($signed(d[SW-1:0]));
    y = longint'($signed(d[2*SW-1:SW]));
    z = longint'($signed(d[3*SW-1:2*SW]));
    sc = 64'sd1 << (32 - SW);
    if (x == 0 && y == 0 && z == 0) begin
      r.tilt = '0; r.roll = '0; r.pitch = '0; r.zero = 1'b1;
      return r;
    end
    tilt = round_to_frac(cordic_atan2(magnitude(x, y), z * sc));
    if (tilt < 0) tilt = 0;
    if (order == OrderYxz) begin
      roll = round_to_frac(cordic_atan2(y * sc, magnitude(x, z)));
      pitch = round_to_frac(cordic_atan2(-x * sc, z * sc));
    end else begin
      roll = round_to_frac(cordic_atan2(y * sc, z * sc));
      pitch = round_to_frac(cordic_atan2(-x * sc, magnitude(y, z)));
    end
    r.tilt = tilt[FB+1:0];
    r.roll = roll[FB+2:0];
    r.pitch = pitch[FB+2:0];
    r.zero = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    n_errors++;
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (no_idle || sel < 60) return 0;
    if (sel < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      gap_cnt <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        angles_expected.push_back(predict_angles(s_tdata, order_model));
        n_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_cnt > 0) begin
          gap_cnt <= gap_cnt - 1;
          s_tvalid <= 1'b0;
        end else if (!sender_hold && sample_queue.size() > 0) begin
          s_tdata <= sample_queue.pop_front();
          s_tvalid <= 1'b1;
          gap_cnt <= pick_gap();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
      stall_cnt <= 0;
      long_stall_cnt <= 0;
    end else if (!long_stall_done && n_sent >= 120) begin
      long_stall_done <= 1'b1;
      long_stall_cnt <= 400;
      m_tready <= 1'b0;
    end else if (long_stall_cnt > 0) begin
      long_stall_cnt <= long_stall_cnt - 1;
      m_tready <= 1'b0;
    end else if (stall_cnt > 0) begin
      stall_cnt <= stall_cnt - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      stall_cnt <= pick_gap();
    end
  end

  always @(posedge clk_i) begin
    angles_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      if (angles_expected.size() == 0) begin
        report_mismatch("result with no sample pending", m_tdata, 0);
      end else begin
        want = angles_expected.pop_front();
        n_checked++;
        if (m_tuser) n_zero++;
        if (m_tdata[FB+1:0] !== want.tilt) report_mismatch("tilt", m_tdata[FB+1:0], want.tilt);
        if (m_tdata[2*FB+4:FB+2] !== want.roll)
          report_mismatch("roll", m_tdata[2*FB+4:FB+2], want.roll);
        if (m_tdata[3*FB+7:2*FB+5] !== want.pitch)
          report_mismatch("pitch", m_tdata[3*FB+7:2*FB+5], want.pitch);
        if (m_tuser !== want.zero) report_mismatch("zero_input", m_tuser, want.zero);
      end
    end
  end

  function automatic logic [SW-1:0] random_axis(int kind);
    logic [SW-1:0] edges[6];
    edges = '{16'h8000, 16'h8001, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFF};
    case (kind)
      0: return SW'($urandom());
      1: return SW'($signed($urandom_range(0, 16)) - 8);
      2: return edges[$urandom_range(0, 5)];
      default: return ($urandom_range(0, 2) == 0) ? '0 : SW'($urandom());
    endcase
  endfunction

  function automatic logic [InW-1:0] random_sample();
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 5) kind = 0;
    else if (kind < 7) kind = 1;
    else if (kind < 8) kind = 2;
    else kind = 3;
    return {random_axis(kind), random_axis(kind), random_axis(kind)};
  endfunction

  task automatic load_directed();
    logic [SW-1:0] cases[14][3];
    cases = '{
      '{16'h0000, 16'h0000, 16'h0000}, '{16'h0000, 16'h0000, 16'h0001},
      '{16'h0000, 16'h0000, 16'h8000}, '{16'h0000, 16'h0005, 16'h0000},
      '{16'h0003, 16'h0000, 16'h0000}, '{16'h0000, 16'h0004, 16'hFFF0},
      '{16'h8000, 16'h8000, 16'h8000}, '{16'h7FFF, 16'h7FFF, 16'h7FFF},
      '{16'h8000, 16'h7FFF, 16'h0000}, '{16'h7FFF, 16'h8000, 16'hFFFF},
      '{16'hFFFF, 16'h0000, 16'h0000}, '{16'h0000, 16'hFFFF, 16'h0000},
      '{16'h5555, 16'hAAAA, 16'h5555}, '{16'hAAAA, 16'h5555, 16'hAAAA}};
    foreach (cases[i]) sample_queue.push_back({cases[i][2], cases[i][1], cases[i][0]});
  endtask

  task automatic run_phase(bit order, int n_random, bit directed, bit busy);
    sender_hold = 1'b1;
    @(posedge clk_i);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= order;
    @(posedge clk_i);
    cfg_wr_en <= 1'b0;
    order_model = order;
    no_idle = busy;
    if (directed) load_directed();
    repeat (n_random) sample_queue.push_back(random_sample());
    sender_hold = 1'b0;
    wait (sample_queue.size() == 0 && !s_tvalid && angles_expected.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    run_phase(OrderXyz, 0, 1'b1, 1'b0);
    run_phase(OrderYxz, 0, 1'b1, 1'b0);
    run_phase(OrderYxz, 150, 1'b0, 1'b1);
    run_phase(OrderXyz, 150, 1'b0, 1'b0);
    run_phase(OrderYxz, 120, 1'b0, 1'b0);
    $display("Covered %0d samples (%0d all-zero) over both Euler orders, with stalls and gaps.",
             n_checked, n_zero);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches found.", n_errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
